// File: rtl/gech_pkg.sv
// Package for the grid edge crossing block: state, command and status types, register
// indexes and reset values. No dependencies; used by every module of the block.
package gech_pkg;

   localparam int DEF_MAX_WIDTH = 1024;   // default line store depth
   localparam int MAX_HEIGHT    = 1024;   // rows in use are limited to this
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int DIV_STEPS     = 32;     // quotient bits, one per cycle
   localparam int DIV_CNT_W     = 5;

   localparam logic [CSR_IDX_W-1:0] REG_GRID_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_X    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Y    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CELL_SIZE_X = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CELL_SIZE_Y = 3'd5;

   localparam logic [10:0] RST_GRID_WIDTH  = 11'd32;
   localparam logic [10:0] RST_GRID_HEIGHT = 11'd32;
   localparam logic [30:0] RST_CELL_SIZE   = 31'd2048;

   typedef enum logic [2:0] {
      S_IDLE,     // waiting for an item
      S_EVAL,     // neighbour read back, sign tests
      S_PICK,     // choose next crossing or finish
      S_DIV,      // divider stepping
      S_FIN,      // final sums into output register
      S_COMMIT    // update neighbours and counters
   } gech_state_type;

   typedef struct packed {
      logic accept;
      logic eval;
      logic mul;
      logic div_step;
      logic load_out;
      logic commit;
   } gech_cmd_type;

   typedef struct packed {
      logic pend_any;
      logic div_last;
      logic out_free;
   } gech_sts_type;

endpackage

// File: rtl/gech_ctrl.sv
// Controller of the grid edge crossing block: sequences one item through the datapath.
// Depends on gech_pkg.
module gech_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  gech_pkg::gech_sts_type sts,
   output gech_pkg::gech_cmd_type cmd
);

   gech_pkg::gech_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gech_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gech_pkg::S_IDLE: begin
            if (req_valid) state_in = gech_pkg::S_EVAL;
         end
         gech_pkg::S_EVAL:   state_in = gech_pkg::S_PICK;
         gech_pkg::S_PICK: begin
            state_in = sts.pend_any ? gech_pkg::S_DIV : gech_pkg::S_COMMIT;
         end
         gech_pkg::S_DIV: begin
            if (sts.div_last) state_in = gech_pkg::S_FIN;
         end
         gech_pkg::S_FIN: begin
            if (sts.out_free) state_in = gech_pkg::S_PICK;
         end
         gech_pkg::S_COMMIT: state_in = gech_pkg::S_IDLE;
         default:            state_in = gech_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         gech_pkg::S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         gech_pkg::S_EVAL:   cmd.eval     = 1'b1;
         gech_pkg::S_PICK:   cmd.mul      = sts.pend_any;
         gech_pkg::S_DIV:    cmd.div_step = 1'b1;
         gech_pkg::S_FIN:    cmd.load_out = sts.out_free;
         gech_pkg::S_COMMIT: cmd.commit   = 1'b1;
         default: ;
      endcase
   end

   // result only loaded for a pending crossing into a free output register
   a_load_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (sts.pend_any && sts.out_free))
      else $error("load without pending crossing");

   // neighbours never updated while a crossing is outstanding
   a_commit_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !sts.pend_any)
      else $error("commit with pending crossing");

   // divider runs its full length
   a_div_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gech_pkg::S_DIV && !sts.div_last) |=> (state_ff == gech_pkg::S_DIV))
      else $error("divider left early");

   // a new item only after the previous one committed
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> (state_ff == gech_pkg::S_EVAL && $past(state_ff) == gech_pkg::S_IDLE))
      else $error("accept outside idle");

endmodule

// File: rtl/gech_dp.sv
// Datapath of the grid edge crossing block: config registers, line store, neighbour
// registers, multipliers, three-lane shared divider and output register. Depends on gech_pkg.
module gech_dp #(
   parameter int MAX_WIDTH = gech_pkg::DEF_MAX_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [gech_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gech_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic signed [31:0]                req_level_value,
   input  logic signed [31:0]                req_grad_x,
   input  logic signed [31:0]                req_grad_y,
   input  gech_pkg::gech_cmd_type            cmd,
   output gech_pkg::gech_sts_type            sts,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic                              rsp_face_axis,
   output logic [9:0]                        rsp_face_col,
   output logic [9:0]                        rsp_face_row,
   output logic signed [31:0]                rsp_cross_x,
   output logic signed [31:0]                rsp_cross_y,
   output logic signed [31:0]                rsp_normal_x,
   output logic signed [31:0]                rsp_normal_y,
   output logic                              rsp_last
);

   localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int OXW = CW + 2;           // 2i+1
   localparam int SW  = OXW + 33;         // position sums

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      mag32 = v[31] ? (~v + 32'd1) : v;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647)        sat32 = 32'sh7FFFFFFF;
      else if (v < -64'sd2147483648)  sat32 = 32'sh80000000;
      else                            sat32 = v[31:0];
   endfunction

   // ---- configuration
   logic [10:0]        gw_ff, gh_ff;
   logic signed [31:0] ox_ff, oy_ff;
   logic [30:0]        hx_ff, hy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gw_ff <= gech_pkg::RST_GRID_WIDTH;
         gh_ff <= gech_pkg::RST_GRID_HEIGHT;
         ox_ff <= '0;
         oy_ff <= '0;
         hx_ff <= gech_pkg::RST_CELL_SIZE;
         hy_ff <= gech_pkg::RST_CELL_SIZE;
      end else if (csr_write) begin
         case (csr_index)
            gech_pkg::REG_GRID_WIDTH:  gw_ff <= csr_wdata[10:0];
            gech_pkg::REG_GRID_HEIGHT: gh_ff <= csr_wdata[10:0];
            gech_pkg::REG_ORIGIN_X:    ox_ff <= csr_wdata;
            gech_pkg::REG_ORIGIN_Y:    oy_ff <= csr_wdata;
            gech_pkg::REG_CELL_SIZE_X: hx_ff <= csr_wdata[30:0];
            gech_pkg::REG_CELL_SIZE_Y: hy_ff <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // ---- current item, line store, left neighbour
   logic signed [31:0] lv_ff, gx_ff, gy_ff;
   logic signed [31:0] left_lv_ff, left_gx_ff, left_gy_ff;
   logic [95:0]        line_mem [MAX_WIDTH];
   logic [95:0]        line_rd_ff;
   logic [CW-1:0]      col_ff;
   logic [9:0]         row_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         lv_ff      <= req_level_value;
         gx_ff      <= req_grad_x;
         gy_ff      <= req_grad_y;
         line_rd_ff <= line_mem[col_ff];
      end
      if (cmd.commit) line_mem[col_ff] <= {lv_ff, gx_ff, gy_ff};
   end

   logic signed [31:0] nb_lv, nb_gx, nb_gy;
   assign nb_lv = signed'(line_rd_ff[95:64]);
   assign nb_gx = signed'(line_rd_ff[63:32]);
   assign nb_gy = signed'(line_rd_ff[31:0]);

   // width and height in use
   logic [12:0] gw_wide, w_lim;
   logic [CW:0] w_use, col_inc;
   logic [10:0] h_use, row_inc;
   logic        col_wrap, row_wrap;

   assign gw_wide = 13'(gw_ff);
   always_comb begin
      if (gw_wide == 13'd0)                 w_lim = 13'd1;
      else if (gw_wide > 13'(MAX_WIDTH))    w_lim = 13'(MAX_WIDTH);
      else                                  w_lim = gw_wide;
      if (gh_ff == 11'd0)                          h_use = 11'd1;
      else if (gh_ff > 11'(gech_pkg::MAX_HEIGHT))  h_use = 11'(gech_pkg::MAX_HEIGHT);
      else                                         h_use = gh_ff;
   end
   assign w_use    = (CW+1)'(w_lim);
   assign col_inc  = {1'b0, col_ff} + (CW+1)'(1);
   assign col_wrap = (col_inc >= w_use);
   assign row_inc  = {1'b0, row_ff} + 11'd1;
   assign row_wrap = (row_inc >= h_use);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         left_lv_ff <= '0;
         left_gx_ff <= '0;
         left_gy_ff <= '0;
      end else if (cmd.commit) begin
         left_lv_ff <= lv_ff;
         left_gx_ff <= gx_ff;
         left_gy_ff <= gy_ff;
         if (col_wrap) begin
            col_ff <= '0;
            row_ff <= row_wrap ? 10'd0 : row_inc[9:0];
         end else begin
            col_ff <= col_inc[CW-1:0];
         end
      end
   end

   // ---- pending crossings
   logic pend_left_ff, pend_low_ff, axis_ff, cur_axis;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_left_ff <= 1'b0;
         pend_low_ff  <= 1'b0;
      end else if (cmd.eval) begin
         pend_left_ff <= (col_ff != '0) && (left_lv_ff[31] != lv_ff[31]);
         pend_low_ff  <= (row_ff != '0) && (nb_lv[31] != lv_ff[31]);
      end else if (cmd.load_out) begin
         if (axis_ff) pend_low_ff  <= 1'b0;
         else         pend_left_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) axis_ff <= !pend_left_ff;
   end

   // left crossing first; axis held from the multiply cycle on
   assign cur_axis = cmd.mul ? !pend_left_ff : axis_ff;

   // ---- neighbour A against current cell C
   logic signed [31:0] a_lv, a_gx, a_gy;
   logic [31:0]        pa, pc, mdx, mdy;
   logic [32:0]        den;
   logic signed [32:0] dx, dy;
   logic [30:0]        h_off;
   logic [OXW-1:0]     odd_x;
   logic [10:0]        odd_y;

   assign a_lv  = cur_axis ? nb_lv : left_lv_ff;
   assign a_gx  = cur_axis ? nb_gx : left_gx_ff;
   assign a_gy  = cur_axis ? nb_gy : left_gy_ff;
   assign pa    = mag32(a_lv);
   assign pc    = mag32(lv_ff);
   assign den   = {1'b0, pa} + {1'b0, pc};
   assign dx    = 33'(gx_ff) - 33'(a_gx);
   assign dy    = 33'(gy_ff) - 33'(a_gy);
   assign mdx   = dx[32] ? 32'(-dx) : dx[31:0];
   assign mdy   = dy[32] ? 32'(-dy) : dy[31:0];
   assign h_off = cur_axis ? hy_ff : hx_ff;
   assign odd_x = cur_axis ? {1'b0, col_ff, 1'b1} : ({1'b0, col_ff, 1'b1} - OXW'(2));
   assign odd_y = cur_axis ? ({row_ff, 1'b1} - 11'd2) : {row_ff, 1'b1};

   logic [63:0]        num [3];
   logic [OXW+30:0]    cxp;
   logic [41:0]        cyp;
   logic [OXW+29:0]    cx_ff;
   logic [40:0]        cy_ff;

   assign num[0] = {1'b0, h_off} * pa;
   assign num[1] = mdx * pa;
   assign num[2] = mdy * pa;
   assign cxp    = odd_x * hx_ff;
   assign cyp    = odd_y * hy_ff;

   // ---- divider, three lanes sharing the denominator, one quotient bit per step
   logic [32:0]                     den_ff;
   logic [32:0]                     rem_ff [3];
   logic [31:0]                     quo_ff [3];
   logic [gech_pkg::DIV_CNT_W-1:0]  div_cnt_ff;
   logic [33:0]                     trial  [3];
   logic                            ge     [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         trial[k] = {rem_ff[k], quo_ff[k][31]};
         ge[k]    = (trial[k] >= {1'b0, den_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         den_ff     <= den;
         cx_ff      <= cxp[OXW+30:1];
         cy_ff      <= cyp[41:1];
         div_cnt_ff <= '0;
         for (int k = 0; k < 3; k++) begin
            rem_ff[k] <= {1'b0, num[k][63:32]};   // below den since the quotient fits 32 bits
            quo_ff[k] <= num[k][31:0];
         end
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff + gech_pkg::DIV_CNT_W'(1);
         for (int k = 0; k < 3; k++) begin
            rem_ff[k] <= ge[k] ? 33'(trial[k] - {1'b0, den_ff}) : trial[k][32:0];
            quo_ff[k] <= {quo_ff[k][30:0], ge[k]};
         end
      end
   end

   // ---- final sums
   logic signed [SW-1:0] x_sum, y_sum;
   logic signed [33:0]   nx_sum, ny_sum;
   logic [31:0]          off_x, off_y;

   assign off_x  = axis_ff ? 32'd0 : quo_ff[0];
   assign off_y  = axis_ff ? quo_ff[0] : 32'd0;
   assign x_sum  = SW'(ox_ff) + signed'(SW'(cx_ff)) + signed'(SW'(off_x));
   assign y_sum  = SW'(oy_ff) + signed'(SW'(cy_ff)) + signed'(SW'(off_y));
   assign nx_sum = dx[32] ? (34'(a_gx) - signed'({2'b00, quo_ff[1]}))
                          : (34'(a_gx) + signed'({2'b00, quo_ff[1]}));
   assign ny_sum = dy[32] ? (34'(a_gy) - signed'({2'b00, quo_ff[2]}))
                          : (34'(a_gy) + signed'({2'b00, quo_ff[2]}));

   // ---- output register
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset)              rsp_valid_ff <= 1'b0;
      else if (cmd.load_out)  rsp_valid_ff <= 1'b1;
      else if (rsp_ready)     rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_face_axis <= axis_ff;
         rsp_face_col  <= 10'(col_ff);
         rsp_face_row  <= row_ff;
         rsp_cross_x   <= sat32(64'(x_sum));
         rsp_cross_y   <= sat32(64'(y_sum));
         rsp_normal_x  <= sat32(64'(nx_sum));
         rsp_normal_y  <= sat32(64'(ny_sum));
         rsp_last      <= axis_ff | !pend_low_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign sts.pend_any = pend_left_ff | pend_low_ff;
   assign sts.div_last = (div_cnt_ff == gech_pkg::DIV_CNT_W'(gech_pkg::DIV_STEPS - 1));
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

endmodule

// File: rtl/grid_edge_crossing_hermite.sv
// Top level of the grid edge crossing block: controller and datapath.
// Depends on gech_pkg, gech_ctrl and gech_dp.
//
//   channel   direction  handshake              carries
//   req_      in         req_valid/req_ready    one grid cell: level, gradient x/y
//   rsp_      out        rsp_valid/rsp_ready    one face crossing, last marks cell end
//   csr_      in         csr_write              register write, index + data
//
// A cell with no crossing passes idle, evaluate, pick and commit; each crossing adds a multiply
// step, the stepping of the shared divider and a step of final sums, which waits for a free output register.
// The divider produces one quotient bit per cycle.
// Reset is synchronous: counters, neighbour register and config go to their reset
// values; the line store is left as is.
// The output register lets work continue while a result waits; the block only stalls
// when the next result is ready and the previous one has not been taken.
module grid_edge_crossing_hermite #(
   parameter int MAX_WIDTH = gech_pkg::DEF_MAX_WIDTH   // line store depth, 2..1024
) (
   input  logic                             clock,
   input  logic                             reset,
   // configuration
   input  logic                             csr_write,
   input  logic [gech_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gech_pkg::CSR_DATA_W-1:0]  csr_wdata,
   // cells in
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [31:0]               req_level_value,
   input  logic signed [31:0]               req_grad_x,
   input  logic signed [31:0]               req_grad_y,
   // crossings out
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_face_axis,
   output logic [9:0]                       rsp_face_col,
   output logic [9:0]                       rsp_face_row,
   output logic signed [31:0]               rsp_cross_x,
   output logic signed [31:0]               rsp_cross_y,
   output logic signed [31:0]               rsp_normal_x,
   output logic signed [31:0]               rsp_normal_y,
   output logic                             rsp_last
);

   gech_pkg::gech_cmd_type cmd;
   gech_pkg::gech_sts_type sts;

   // sequencing: idle, evaluate, then per crossing multiply/divide/finish, commit
   gech_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // arithmetic, line store and output register
   gech_dp #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_level_value (req_level_value),
      .req_grad_x      (req_grad_x),
      .req_grad_y      (req_grad_y),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_face_axis   (rsp_face_axis),
      .rsp_face_col    (rsp_face_col),
      .rsp_face_row    (rsp_face_row),
      .rsp_cross_x     (rsp_cross_x),
      .rsp_cross_y     (rsp_cross_y),
      .rsp_normal_x    (rsp_normal_x),
      .rsp_normal_y    (rsp_normal_y),
      .rsp_last        (rsp_last)
   );

endmodule
